>>> rtl/bbc_pkg.sv
// shared types and constants for the bracket balance checker
package bbc_pkg;

  localparam int unsigned MAX_DEPTH_DEF = 64;

  localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28;
  localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;
  localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29;
  localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;
  localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;

  typedef enum logic [1:0] {
    BR_NONE   = 2'd0,
    BR_ROUND  = 2'd1,
    BR_CURLY  = 2'd2,
    BR_SQUARE = 2'd3
  } bracket_t;

  typedef enum logic [2:0] {
    FAULT_NONE     = 3'd0,
    FAULT_MISMATCH = 3'd1,
    FAULT_EMPTY    = 3'd2,
    FAULT_UNCLOSED = 3'd3,
    FAULT_OVERFLOW = 3'd4
  } fault_t;

endpackage

>>> rtl/bracket_balance_checker_unit.sv
// top level of the bracket balance checker
//
// The input channel (in_valid, in_stall, in_char_in, in_last_char) takes one
// byte of a string per item; in_last_char marks the final byte. Opening
// brackets are pushed onto a stack held in a ram, closing brackets must match
// the top and pop it, all other bytes are ignored. The first fault of a string
// is kept and later bytes of that string are ignored.
// For the final byte one verdict item leaves on the output channel (out_valid,
// out_stall, out_balanced, out_fault_code) in the cycle after it is taken.
// Non-final bytes give no item.
// Throughput is one byte per cycle while in_stall is low: the top entry and
// the entry below it sit in registers, and the ram read of the next lower
// entry, issued on a pop, lands in time for the following cycle.
// The verdict sits in an output register; in_stall is raised only while that
// register is full and out_stall is high.
// Synchronous reset (rst_n low) empties the stack, clears the fault and drops
// out_valid. The state also clears after each final byte.
module bracket_balance_checker_unit #(
  parameter int unsigned MAX_DEPTH = bbc_pkg::MAX_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_char_in,
  input  logic            in_last_char,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_balanced,
  output bbc_pkg::fault_t out_fault_code
);

  import bbc_pkg::*;

  localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int unsigned ADDR_W  = $clog2(MAX_DEPTH);

  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  fault_t             fault_r, fault_nxt;
  bracket_t           top_r, top_nxt;
  bracket_t           below_r, below_nxt;
  logic               rd_valid_r, rd_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_balanced_r, out_balanced_nxt;
  fault_t             out_fault_r, out_fault_nxt;

  logic               in_fire;
  bracket_t           open_code, close_code;
  logic [1:0]         rd_data;
  bracket_t           below_eff;
  logic               ram_we, ram_re;
  logic [DEPTH_W-1:0] rd_ptr;
  fault_t             step_fault;
  logic [DEPTH_W-1:0] step_depth;

  assign in_fire   = in_valid && !in_stall;
  assign in_stall  = out_valid_r && out_stall;
  assign below_eff = rd_valid_r ? bracket_t'(rd_data) : below_r;
  assign rd_ptr    = depth_r - DEPTH_W'(3);

  always_comb begin
    open_code  = BR_NONE;
    close_code = BR_NONE;
    unique case (in_char_in)
      CHAR_OPEN_ROUND:   open_code  = BR_ROUND;
      CHAR_OPEN_CURLY:   open_code  = BR_CURLY;
      CHAR_OPEN_SQUARE:  open_code  = BR_SQUARE;
      CHAR_CLOSE_ROUND:  close_code = BR_ROUND;
      CHAR_CLOSE_CURLY:  close_code = BR_CURLY;
      CHAR_CLOSE_SQUARE: close_code = BR_SQUARE;
      default: ;
    endcase
  end

  always_comb begin
    step_fault   = fault_r;
    step_depth   = depth_r;
    top_nxt      = top_r;
    below_nxt    = below_eff;
    rd_valid_nxt = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    if (in_fire && fault_r == FAULT_NONE) begin
      if (open_code != BR_NONE) begin
        if (depth_r == DEPTH_W'(MAX_DEPTH)) begin
          step_fault = FAULT_OVERFLOW;
        end else begin
          ram_we     = 1'b1;
          step_depth = depth_r + DEPTH_W'(1);
          top_nxt    = open_code;
          below_nxt  = top_r;
        end
      end else if (close_code != BR_NONE) begin
        if (depth_r == '0) begin
          step_fault = FAULT_EMPTY;
        end else if (top_r != close_code) begin
          step_fault = FAULT_MISMATCH;
        end else begin
          step_depth   = depth_r - DEPTH_W'(1);
          top_nxt      = below_eff;
          ram_re       = depth_r >= DEPTH_W'(3);
          rd_valid_nxt = ram_re;
        end
      end
    end
  end

  always_comb begin
    depth_nxt        = step_depth;
    fault_nxt        = step_fault;
    out_valid_nxt    = out_valid_r && out_stall;
    out_balanced_nxt = out_balanced_r;
    out_fault_nxt    = out_fault_r;
    if (in_fire && in_last_char) begin
      out_valid_nxt = 1'b1;
      if (step_fault == FAULT_NONE && step_depth != '0) begin
        out_fault_nxt = FAULT_UNCLOSED;
      end else begin
        out_fault_nxt = step_fault;
      end
      out_balanced_nxt = (out_fault_nxt == FAULT_NONE);
      depth_nxt        = '0;
      fault_nxt        = FAULT_NONE;
    end
  end

  bbc_ram #(
    .WIDTH (2),
    .DEPTH (MAX_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (depth_r[ADDR_W-1:0]),
    .wdata (open_code),
    .re    (ram_re),
    .raddr (rd_ptr[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      fault_r     <= FAULT_NONE;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      depth_r     <= depth_nxt;
      fault_r     <= fault_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r          <= top_nxt;
    below_r        <= below_nxt;
    out_balanced_r <= out_balanced_nxt;
    out_fault_r    <= out_fault_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_balanced   = out_balanced_r;
  assign out_fault_code = out_fault_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(MAX_DEPTH))
    else $error("stack depth beyond its bound");

  a_verdict_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_balanced_r == (out_fault_r == FAULT_NONE)))
    else $error("balanced flag disagrees with fault code");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last_char |=> depth_r == '0 && fault_r == FAULT_NONE && out_valid_r)
    else $error("state not cleared or verdict missing after final byte");

  a_read_only_when_deep: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> depth_r >= DEPTH_W'(3) && !ram_we)
    else $error("stack read issued without a lower entry");

endmodule

>>> rtl/bbc_ram.sv
// generic single-port-write ram with registered read
module bbc_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> verif/tb_bracket_balance_checker_unit.sv
// testbench for the bracket balance checker: directed and random strings checked against a predictor
import bbc_pkg::*;

typedef struct packed {
  logic   balanced;
  fault_t fault_code;
} verdict_t;

typedef logic [7:0] text_q_t[$];

class verdict_scoreboard;
  bracket_t    open_codes[MAX_DEPTH_DEF];
  int unsigned open_depth;
  fault_t      first_fault;
  verdict_t    pending_verdicts[$];
  int unsigned mismatches;

  function new();
    open_depth  = 0;
    first_fault = FAULT_NONE;
    mismatches  = 0;
  endfunction

  function void note_byte(logic [7:0] ch, logic last);
    bracket_t opener;
    bracket_t closer;
    verdict_t v;
    opener = BR_NONE;
    closer = BR_NONE;
    case (ch)
      CHAR_OPEN_ROUND:   opener = BR_ROUND;
      CHAR_OPEN_CURLY:   opener = BR_CURLY;
      CHAR_OPEN_SQUARE:  opener = BR_SQUARE;
      CHAR_CLOSE_ROUND:  closer = BR_ROUND;
      CHAR_CLOSE_CURLY:  closer = BR_CURLY;
      CHAR_CLOSE_SQUARE: closer = BR_SQUARE;
      default: ;
    endcase
    if (first_fault == FAULT_NONE) begin
      if (opener != BR_NONE) begin
        if (open_depth >= MAX_DEPTH_DEF) first_fault = FAULT_OVERFLOW;
        else begin
          open_codes[open_depth] = opener;
          open_depth++;
        end
      end else if (closer != BR_NONE) begin
        if (open_depth == 0) first_fault = FAULT_EMPTY;
        else if (open_codes[open_depth - 1] != closer) first_fault = FAULT_MISMATCH;
        else open_depth--;
      end
    end
    if (last) begin
      v.fault_code = first_fault;
      if (v.fault_code == FAULT_NONE && open_depth != 0) v.fault_code = FAULT_UNCLOSED;
      v.balanced = (v.fault_code == FAULT_NONE);
      pending_verdicts.push_back(v);
      open_depth  = 0;
      first_fault = FAULT_NONE;
    end
  endfunction

  task report(string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task check_verdict(logic balanced, fault_t fault_code);
    verdict_t want;
    if (pending_verdicts.size() == 0) begin
      report($sformatf("verdict balanced=%0b fault=%0d with nothing expected",
                       balanced, fault_code));
      return;
    end
    want = pending_verdicts.pop_front();
    if (balanced !== want.balanced)
      report($sformatf("balanced got %0b expected %0b", balanced, want.balanced));
    if (fault_code !== want.fault_code)
      report($sformatf("fault_code got %0d expected %0d", fault_code, want.fault_code));
  endtask
endclass

module tb_bracket_balance_checker_unit;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 600;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_in = 8'h00;
  logic       in_last_char = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_balanced;
  fault_t     out_fault_code;

  verdict_scoreboard board = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;

  bracket_balance_checker_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_in     (in_char_in),
    .in_last_char   (in_last_char),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_balanced   (out_balanced),
    .out_fault_code (out_fault_code)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_verdict(out_balanced, out_fault_code);
  end

  function automatic logic [7:0] open_char(bracket_t kind);
    case (kind)
      BR_ROUND: return CHAR_OPEN_ROUND;
      BR_CURLY: return CHAR_OPEN_CURLY;
      default:  return CHAR_OPEN_SQUARE;
    endcase
  endfunction

  function automatic logic [7:0] close_char(bracket_t kind);
    case (kind)
      BR_ROUND: return CHAR_CLOSE_ROUND;
      BR_CURLY: return CHAR_CLOSE_CURLY;
      default:  return CHAR_CLOSE_SQUARE;
    endcase
  endfunction

  function automatic bracket_t random_kind();
    return bracket_t'($urandom_range(BR_ROUND, BR_SQUARE));
  endfunction

  function automatic text_q_t to_text(string s);
    text_q_t text;
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    return text;
  endfunction

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_byte(input logic [7:0] ch, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_char_in   <= ch;
    in_last_char <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_byte(ch, last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input text_q_t text);
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic build_string(ref text_q_t text);
    bracket_t    open_kinds[$];
    bracket_t    kind;
    int unsigned shape;
    int unsigned len;
    int unsigned pick;
    int unsigned pos;
    text.delete();
    shape = $urandom_range(0, 99);
    if (shape < 3) begin
      // nesting around the stack limit
      len = $urandom_range(MAX_DEPTH_DEF - 1, MAX_DEPTH_DEF + 3);
      repeat (len) begin
        kind = random_kind();
        open_kinds.push_back(kind);
        text.push_back(open_char(kind));
      end
      while (open_kinds.size() > 0) text.push_back(close_char(open_kinds.pop_back()));
    end else if (shape < 15) begin
      len = $urandom_range(1, 8);
      repeat (len) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      len = $urandom_range(1, 20);
      repeat (len) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          kind = random_kind();
          open_kinds.push_back(kind);
          text.push_back(open_char(kind));
        end else if (pick < 8 && open_kinds.size() > 0) begin
          text.push_back(close_char(open_kinds.pop_back()));
        end else begin
          text.push_back(8'($urandom_range(0, 255)));
        end
      end
      while (open_kinds.size() > 0) text.push_back(close_char(open_kinds.pop_back()));
      if (shape >= 75) begin
        // break an otherwise well-formed string
        pos = $urandom_range(0, text.size() - 1);
        case (shape % 3)
          0: text[pos] = close_char(random_kind());
          1: if (text.size() > 1) text.delete(pos);
          default: text.insert(pos, open_char(random_kind()));
        endcase
      end
    end
  endtask

  initial begin
    text_q_t text;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_text(to_text("()"));
    send_text(to_text("{}"));
    send_text(to_text("[]"));
    send_text(to_text("(]"));
    send_text(to_text(")"));
    send_text(to_text("[("));
    send_text(to_text("}()"));
    send_text(to_text("{a}"));

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 53 : 0;
      recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 16 : 0;
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) begin
        build_string(text);
        send_text(text);
      end
      if (phase == 0) begin
        // let the block drain completely before going on
        in_valid <= 1'b0;
        @(negedge clk);
        while (board.pending_verdicts.size() != 0) @(negedge clk);
      end
    end

    in_valid <= 1'b0;
    while (board.pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (board.mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

>>> sim.f
rtl/bbc_pkg.sv
rtl/bbc_ram.sv
rtl/bracket_balance_checker_unit.sv
verif/tb_bracket_balance_checker_unit.sv
